/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define CRPP_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CRPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/crpp_pkg.sv */
`default_nettype none

package crpp_pkg;

    localparam int VAL_W  = 64;
    localparam int KW_LEN = 5;

    // Unit keyword, letter k in byte k.
    localparam logic [KW_LEN-1:0][7:0] KW_WORD = {8'h73, 8'h65, 8'h74, 8'h79, 8'h62};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_DIGIT,
        CLS_DASH,
        CLS_SLASH,
        CLS_STAR,
        CLS_OTHER
    } t_cls;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_KEY,
        PH_GAP,
        PH_START,
        PH_END,
        PH_SIZE_FIRST,
        PH_SIZE_DIGITS,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        POS_UNKNOWN = 3'd0,
        POS_FULL    = 3'd1,
        POS_START   = 3'd2,
        POS_MIDDLE  = 3'd3,
        POS_END     = 3'd4
    } t_pos;

    typedef struct packed {
        t_cls              cls;
        logic [3:0]        digit;
        logic [KW_LEN-1:0] kw_hit;
        logic              final_byte;
        logic              piece_is_front;
        logic              piece_is_back;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qhead;

    typedef struct packed {
        logic pop;
        logic pop_final;
    } t_back_stat;

endpackage

`default_nettype wire

/* hw/rtl/crpp_if.sv */
`default_nettype none

interface crpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       final_byte;
    logic       piece_is_front;
    logic       piece_is_back;

    modport source (output valid, header_byte, final_byte, piece_is_front, piece_is_back,
                    input ready);
    modport sink   (input valid, header_byte, final_byte, piece_is_front, piece_is_back,
                    output ready);
endinterface

interface crpp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] piece_pos;

    modport source (output valid, piece_pos, input ready);
    modport sink   (input valid, piece_pos, output ready);
endinterface

`default_nettype wire

/* hw/rtl/content_range_position_parser.sv */
// Path: a header byte is written into the queue on its transfer, popped by the back end, and the
//   final byte's position registered; a held, unread result stops the pops.
// Throughput: one byte per cycle, set by the single multiply-by-ten accumulator in the back end.
// Reset: synchronous active-low i_rst_n clears the queue, the parser and the result valid.
`default_nettype none
`include "assert_macros.svh"

module content_range_position_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    crpp_in_if.sink     i_item,
    crpp_out_if.source  o_result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    crpp_pkg::t_entry     w_entry;
    crpp_pkg::t_qhead     w_head;
    crpp_pkg::t_back_stat w_stat;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic [CNT_W-1:0]     w_count;

    // Front end: classify each transferred byte and push it into the queue.
    crpp_front u_front (
        .i_item   (i_item),
        .i_q_full (w_full),
        .o_entry  (w_entry),
        .o_push   (w_push)
    );

    // Short queue: lets the parser stall on a held result without blocking input until it fills.
    crpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_count (w_count),
        .o_head  (w_head)
    );

    // Back end: advance the parse one byte per pop, decide on the final byte,
    // and hold the result in its output register until transferred.
    crpp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

    `CRPP_ASSERT_ALWAYS(a_count_bound, w_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `CRPP_ASSERT_IMPL(a_pop_nonempty, w_pop, w_count != '0, "pop from empty queue")
    `CRPP_ASSERT_IMPL(a_result_source, $rose(o_result.valid), $past(w_stat.pop_final),
        "result without final byte")

endmodule

`default_nettype wire

/* hw/rtl/crpp_front.sv */
`default_nettype none

module crpp_front (
    crpp_in_if.sink         i_item,
    input  wire logic       i_q_full,
    output crpp_pkg::t_entry o_entry,
    output logic            o_push
);

    logic [7:0] w_byte;

    assign w_byte       = i_item.header_byte;
    assign i_item.ready = !i_q_full;
    assign o_push       = i_item.valid && !i_q_full;

    always_comb begin
        o_entry.digit          = 4'(w_byte - crpp_pkg::CH_ZERO);
        o_entry.final_byte     = i_item.final_byte;
        o_entry.piece_is_front = i_item.piece_is_front;
        o_entry.piece_is_back  = i_item.piece_is_back;
        for (int k = 0; k < crpp_pkg::KW_LEN; k++) begin
            o_entry.kw_hit[k] = (w_byte == crpp_pkg::KW_WORD[k]);
        end
        priority if (w_byte >= crpp_pkg::CH_ZERO && w_byte <= crpp_pkg::CH_NINE) begin
            o_entry.cls = crpp_pkg::CLS_DIGIT;
        end else if (w_byte == crpp_pkg::CH_SPACE) begin
            o_entry.cls = crpp_pkg::CLS_SPACE;
        end else if (w_byte == crpp_pkg::CH_DASH) begin
            o_entry.cls = crpp_pkg::CLS_DASH;
        end else if (w_byte == crpp_pkg::CH_SLASH) begin
            o_entry.cls = crpp_pkg::CLS_SLASH;
        end else if (w_byte == crpp_pkg::CH_STAR) begin
            o_entry.cls = crpp_pkg::CLS_STAR;
        end else begin
            o_entry.cls = crpp_pkg::CLS_OTHER;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/crpp_queue.sv */
`default_nettype none

module crpp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire crpp_pkg::t_entry         i_entry,
    input  wire logic                     i_pop,
    output logic                          o_full,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output crpp_pkg::t_qhead              o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    crpp_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_do_pop;

    assign w_do_pop     = i_pop && (r_count != '0);
    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_count      = r_count;
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            unique case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/crpp_back.sv */
`default_nettype none

module crpp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire crpp_pkg::t_qhead i_head,
    output logic                 o_pop,
    output crpp_pkg::t_back_stat o_stat,
    crpp_out_if.source           o_result
);

    localparam int VW = crpp_pkg::VAL_W;
    localparam int AW = VW + 4;

    crpp_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_kidx, n_kidx;
    logic             r_failed, n_failed;
    logic             r_start_nz, n_start_nz;
    logic             r_start_ovf, n_start_ovf;
    logic [VW-1:0]    r_end, n_end;
    logic             r_end_ovf, n_end_ovf;
    logic [VW-1:0]    r_size, n_size;
    logic             r_size_ovf, n_size_ovf;
    logic             r_star, n_star;
    logic             r_out_valid;
    crpp_pkg::t_pos   r_pos;
    crpp_pkg::t_pos   w_pos;

    crpp_pkg::t_entry w_e;
    logic             w_is_digit;
    logic             w_use_size;
    logic [VW-1:0]    w_acc_in;
    logic             w_acc_ovf_in;
    logic [AW-1:0]    w_acc_ext;
    logic [AW-1:0]    w_acc_sum;
    logic [VW-1:0]    w_acc_val;
    logic             w_acc_ovf;
    logic             w_last_pos;
    logic             w_front;
    logic             w_back;

    assign w_e        = i_head.entry;
    assign w_is_digit = (w_e.cls == crpp_pkg::CLS_DIGIT);
    assign o_pop      = i_head.valid && (!r_out_valid || o_result.ready);
    assign o_stat.pop       = o_pop;
    assign o_stat.pop_final = o_pop && w_e.final_byte;

    // Shared multiply-by-ten accumulator, saturating once it overflows.
    assign w_use_size   = (r_phase == crpp_pkg::PH_SIZE_FIRST)
                       || (r_phase == crpp_pkg::PH_SIZE_DIGITS);
    assign w_acc_in     = w_use_size ? r_size : r_end;
    assign w_acc_ovf_in = w_use_size ? r_size_ovf
                        : ((r_phase == crpp_pkg::PH_END) ? r_end_ovf : r_start_ovf);
    assign w_acc_ext    = {4'b0, w_acc_in};
    assign w_acc_sum    = (w_acc_ext << 3) + (w_acc_ext << 1) + AW'(w_e.digit);
    assign w_acc_ovf    = w_acc_ovf_in || (|w_acc_sum[AW-1:VW]);
    assign w_acc_val    = w_acc_ovf_in ? w_acc_in
                        : (w_acc_ovf ? {VW{1'b1}} : w_acc_sum[VW-1:0]);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (!r_failed) begin
            unique case (r_phase)
                crpp_pkg::PH_LEAD: begin
                    if (w_e.cls != crpp_pkg::CLS_SPACE) n_phase = crpp_pkg::PH_KEY;
                end
                crpp_pkg::PH_KEY: begin
                    if (w_e.kw_hit[r_kidx] && r_kidx == 3'(crpp_pkg::KW_LEN - 1)) begin
                        n_phase = crpp_pkg::PH_GAP;
                    end
                end
                crpp_pkg::PH_GAP: begin
                    if (w_is_digit) n_phase = crpp_pkg::PH_START;
                end
                crpp_pkg::PH_START: begin
                    if (w_e.cls == crpp_pkg::CLS_DASH) n_phase = crpp_pkg::PH_END;
                end
                crpp_pkg::PH_END: begin
                    if (w_e.cls == crpp_pkg::CLS_SLASH) n_phase = crpp_pkg::PH_SIZE_FIRST;
                end
                crpp_pkg::PH_SIZE_FIRST: begin
                    n_phase = w_is_digit ? crpp_pkg::PH_SIZE_DIGITS : crpp_pkg::PH_DONE;
                end
                crpp_pkg::PH_SIZE_DIGITS: begin
                    if (!w_is_digit) n_phase = crpp_pkg::PH_DONE;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Field and flag updates.
    always_comb begin
        n_kidx      = r_kidx;
        n_failed    = r_failed;
        n_start_nz  = r_start_nz;
        n_start_ovf = r_start_ovf;
        n_end       = r_end;
        n_end_ovf   = r_end_ovf;
        n_size      = r_size;
        n_size_ovf  = r_size_ovf;
        n_star      = r_star;
        if (!r_failed) begin
            unique case (r_phase)
                crpp_pkg::PH_LEAD: begin
                    if (w_e.cls != crpp_pkg::CLS_SPACE) begin
                        if (w_e.kw_hit[0]) n_kidx = 3'd1;
                        else               n_failed = 1'b1;
                    end
                end
                crpp_pkg::PH_KEY: begin
                    if (w_e.kw_hit[r_kidx]) n_kidx = r_kidx + 3'd1;
                    else                    n_failed = 1'b1;
                end
                crpp_pkg::PH_GAP, crpp_pkg::PH_START: begin
                    if (w_is_digit) begin
                        if (w_e.digit != 4'd0) n_start_nz = 1'b1;
                        n_end       = w_acc_val;
                        n_start_ovf = w_acc_ovf;
                    end else if (r_phase == crpp_pkg::PH_START
                                 && w_e.cls == crpp_pkg::CLS_DASH) begin
                        n_end = '0;
                    end else if (w_e.cls != crpp_pkg::CLS_SPACE
                                 || r_phase == crpp_pkg::PH_START) begin
                        n_failed = 1'b1;
                    end
                end
                crpp_pkg::PH_END: begin
                    if (w_e.cls == crpp_pkg::CLS_SLASH) begin
                        n_failed = r_failed;
                    end else if (w_is_digit) begin
                        n_end     = w_acc_val;
                        n_end_ovf = w_acc_ovf;
                    end else if (!r_start_nz) begin
                        n_failed = 1'b1;
                    end
                end
                crpp_pkg::PH_SIZE_FIRST, crpp_pkg::PH_SIZE_DIGITS: begin
                    if (w_is_digit) begin
                        n_size     = w_acc_val;
                        n_size_ovf = w_acc_ovf;
                    end else if (r_phase == crpp_pkg::PH_SIZE_FIRST
                                 && w_e.cls == crpp_pkg::CLS_STAR) begin
                        n_star = 1'b1;
                    end
                end
                default: n_failed = r_failed;
            endcase
        end
    end

    // Position decision on the state left by the final byte.
    assign w_front    = w_e.piece_is_front;
    assign w_back     = w_e.piece_is_back;
    assign w_last_pos = ({1'b0, n_end} + 1'b1) == {1'b0, n_size};

    always_comb begin
        priority if (n_failed || n_phase < crpp_pkg::PH_SIZE_FIRST || n_start_ovf) begin
            w_pos = crpp_pkg::POS_UNKNOWN;
        end else if (n_start_nz) begin
            w_pos = crpp_pkg::POS_MIDDLE;
        end else if (n_end_ovf || n_end == '0) begin
            w_pos = crpp_pkg::POS_UNKNOWN;
        end else if (!n_star && (n_size_ovf || n_end >= n_size)) begin
            w_pos = crpp_pkg::POS_UNKNOWN;
        end else if (!n_star && w_last_pos) begin
            priority if (w_front && w_back) w_pos = crpp_pkg::POS_FULL;
            else if (w_front)               w_pos = crpp_pkg::POS_START;
            else if (w_back)                w_pos = crpp_pkg::POS_END;
            else                            w_pos = crpp_pkg::POS_MIDDLE;
        end else if (w_front && !w_back) begin
            w_pos = crpp_pkg::POS_START;
        end else begin
            w_pos = crpp_pkg::POS_MIDDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && w_e.final_byte)) begin
            r_phase     <= crpp_pkg::PH_LEAD;
            r_kidx      <= '0;
            r_failed    <= 1'b0;
            r_start_nz  <= 1'b0;
            r_start_ovf <= 1'b0;
            r_end       <= '0;
            r_end_ovf   <= 1'b0;
            r_size      <= '0;
            r_size_ovf  <= 1'b0;
            r_star      <= 1'b0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_kidx      <= n_kidx;
            r_failed    <= n_failed;
            r_start_nz  <= n_start_nz;
            r_start_ovf <= n_start_ovf;
            r_end       <= n_end;
            r_end_ovf   <= n_end_ovf;
            r_size      <= n_size;
            r_size_ovf  <= n_size_ovf;
            r_star      <= n_star;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_e.final_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_e.final_byte) begin
            r_pos <= w_pos;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.piece_pos = r_pos;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    crpp_in_if  in_bus();
    crpp_out_if out_bus();

    content_range_position_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_bus),
        .o_result (out_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser shadow: tracks the header text byte by byte, the same way the
    // block walks it, and yields the file position on the final byte.
    // ------------------------------------------------------------------
    crpp_pkg::t_phase p_phase;
    int unsigned      p_kw;
    logic             p_bad;
    logic             p_start_nz;
    logic             p_start_ovf;
    logic [63:0]      p_end;          // also holds start while start is parsed
    logic             p_end_ovf;
    logic [63:0]      p_size;
    logic             p_size_ovf;
    logic             p_star;

    crpp_pkg::t_pos   pending_positions[$];
    int               fail_count = 0;

    // Idle controls: source gaps and sink stalls can be turned off in stretches.
    bit          src_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int          sink_wait = 0;

    // Text of the header under construction.
    logic [7:0]  msg_bytes[$];
    int          bytes_sent = 0;
    int          msgs_sent = 0;

    function automatic void clear_parser();
        p_phase     = crpp_pkg::PH_LEAD;
        p_kw        = 0;
        p_bad       = 1'b0;
        p_start_nz  = 1'b0;
        p_start_ovf = 1'b0;
        p_end       = '0;
        p_end_ovf   = 1'b0;
        p_size      = '0;
        p_size_ovf  = 1'b0;
        p_star      = 1'b0;
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= crpp_pkg::CH_ZERO && c <= crpp_pkg::CH_NINE;
    endfunction

    // Multiply by ten and add the digit; saturate and flag once past 2^64-1.
    function automatic void mac10(inout logic [63:0] v, inout logic ovf, input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - crpp_pkg::CH_ZERO);
        if (ovf) return;
        if (v > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
            ovf = 1'b1;
            v   = '1;
        end else begin
            v = v * 64'd10 + d;
        end
    endfunction

    function automatic void absorb_byte(logic [7:0] c);
        if (p_bad) return;
        // Leading spaces; the first other byte is already the first keyword letter.
        if (p_phase == crpp_pkg::PH_LEAD) begin
            if (c == crpp_pkg::CH_SPACE) return;
            p_phase = crpp_pkg::PH_KEY;
            p_kw    = 0;
        end
        if (p_phase == crpp_pkg::PH_KEY) begin
            if (p_kw >= crpp_pkg::KW_LEN || c != crpp_pkg::KW_WORD[p_kw]) begin
                p_bad = 1'b1;
                return;
            end
            p_kw++;
            if (p_kw == crpp_pkg::KW_LEN) p_phase = crpp_pkg::PH_GAP;
            return;
        end
        // Gap after the unit; the first digit also starts the start field.
        if (p_phase == crpp_pkg::PH_GAP) begin
            if (c == crpp_pkg::CH_SPACE) return;
            if (!is_num(c)) begin
                p_bad = 1'b1;
                return;
            end
            p_phase = crpp_pkg::PH_START;
        end
        case (p_phase)
            crpp_pkg::PH_START: begin
                if (is_num(c)) begin
                    if (c != crpp_pkg::CH_ZERO) p_start_nz = 1'b1;
                    mac10(p_end, p_start_ovf, c);
                end else if (c == crpp_pkg::CH_DASH) begin
                    p_end   = '0;
                    p_phase = crpp_pkg::PH_END;
                end else begin
                    p_bad = 1'b1;
                end
            end
            crpp_pkg::PH_END: begin
                // With a nonzero start, junk in the end field is tolerated.
                if (c == crpp_pkg::CH_SLASH) p_phase = crpp_pkg::PH_SIZE_FIRST;
                else if (is_num(c)) mac10(p_end, p_end_ovf, c);
                else if (!p_start_nz) p_bad = 1'b1;
            end
            crpp_pkg::PH_SIZE_FIRST: begin
                if (c == crpp_pkg::CH_STAR) begin
                    p_star  = 1'b1;
                    p_phase = crpp_pkg::PH_DONE;
                end else if (is_num(c)) begin
                    mac10(p_size, p_size_ovf, c);
                    p_phase = crpp_pkg::PH_SIZE_DIGITS;
                end else begin
                    p_phase = crpp_pkg::PH_DONE;
                end
            end
            crpp_pkg::PH_SIZE_DIGITS: begin
                if (is_num(c)) mac10(p_size, p_size_ovf, c);
                else p_phase = crpp_pkg::PH_DONE;
            end
            default: ;
        endcase
    endfunction

    function automatic crpp_pkg::t_pos position_for(logic front, logic back);
        logic [63:0] sz;
        if (p_bad || p_phase < crpp_pkg::PH_SIZE_FIRST) return crpp_pkg::POS_UNKNOWN;
        if (p_start_ovf) return crpp_pkg::POS_UNKNOWN;
        if (p_start_nz) return crpp_pkg::POS_MIDDLE;
        if (p_end_ovf || p_end == 64'd0) return crpp_pkg::POS_UNKNOWN;
        if (p_star) begin
            // A star size counts as one, so the piece never reaches the end.
            sz = 64'd1;
        end else begin
            if (p_size_ovf || p_end >= p_size) return crpp_pkg::POS_UNKNOWN;
            sz = p_size;
        end
        if (p_end == sz - 64'd1) begin
            if (front && back) return crpp_pkg::POS_FULL;
            if (front) return crpp_pkg::POS_START;
            if (back) return crpp_pkg::POS_END;
            return crpp_pkg::POS_MIDDLE;
        end
        if (front && !back) return crpp_pkg::POS_START;
        return crpp_pkg::POS_MIDDLE;
    endfunction

    function automatic int draw_wait(bit enabled);
        return enabled ? int'($urandom_range(0, 7)) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one byte per transfer, with a random gap ahead of it.
    // Called right after a rising edge.
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] c, logic fin, logic fr, logic bk);
        int gap;
        gap = draw_wait(src_gaps_on);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.header_byte    <= c;
        in_bus.final_byte     <= fin;
        in_bus.piece_is_front <= fr;
        in_bus.piece_is_back  <= bk;
        // Hold until the transfer happens.
        do @(posedge i_clk); while (!in_bus.ready);
        bytes_sent++;
        absorb_byte(c);
        if (fin) begin
            pending_positions.push_back(position_for(fr, bk));
            clear_parser();
        end
    endtask

    // Flags only matter on the final byte; randomize them everywhere else.
    task automatic send_message(bit fr, bit bk);
        int last;
        last = msg_bytes.size() - 1;
        for (int i = 0; i <= last; i++) begin
            if (i == last) send_byte(msg_bytes[i], 1'b1, fr, bk);
            else send_byte(msg_bytes[i], 1'b0, 1'($urandom), 1'($urandom));
        end
        msgs_sent++;
    endtask

    function automatic void append(string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endfunction

    task automatic send_text(string s, bit fr, bit bk);
        msg_bytes.delete();
        append(s);
        send_message(fr, bk);
    endtask

    // ------------------------------------------------------------------
    // Output side: check each transfer against the oldest prediction, then
    // stall ready for a random number of cycles.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_positions.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, out_bus.piece_pos);
                fail_count++;
            end else begin
                crpp_pkg::t_pos want;
                want = pending_positions.pop_front();
                if (out_bus.piece_pos !== want) begin
                    $display("%0t: piece_pos mismatch, expected %0d, actual %0d",
                             $time, want, out_bus.piece_pos);
                    fail_count++;
                end
            end
            sink_wait = draw_wait(sink_stalls_on);
        end
        if (sink_wait > 0) begin
            out_bus.ready <= 1'b0;
            sink_wait--;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // End equal to size minus one: all four flag combinations, then short pieces.
    task automatic test_position_choice();
        send_text("bytes 0-99/100", 1, 1);
        send_text("bytes 0-99/100", 1, 0);
        send_text("bytes 0-99/100", 0, 1);
        send_text("bytes 0-99/100", 0, 0);
        send_text("  bytes  0-49/100", 1, 0);
        send_text("bytes 0-49/100", 1, 1);
    endtask

    // Only spaces, header cut short, wrong unit, no digit after the gap, junk in start, no size.
    task automatic test_malformed_text();
        send_text("   ", 1, 1);
        send_text("byt", 1, 1);
        send_text("bytez 0-1/2", 1, 1);
        send_text("bytes x0-1/2", 1, 1);
        send_text("bytes 0x-1/2", 1, 1);
        send_text("bytes 0-1", 1, 1);
    endtask

    // Start and end fields: junk after a zero or nonzero start, empty end, signs, spaces, end equal to size.
    task automatic test_range_fields();
        send_text("bytes 7-zz/q", 1, 1);
        send_text("bytes 0-a/7", 1, 1);
        send_text("bytes 0-/5", 1, 1);
        send_text("bytes 0-+5/10", 1, 1);
        send_text("bytes 0- 5/10", 1, 1);
        send_text("bytes 0-10/10", 1, 1);
    endtask

    // Size field: slash last, non-digit, star, trailing bytes.
    task automatic test_size_field();
        send_text("bytes 0-4/", 1, 1);
        send_text("bytes 0-4/x", 1, 1);
        send_text("bytes 0-4/*", 1, 0);
        send_text("bytes 0-9/10;junk", 0, 1);
    endtask

    // 64-bit limits: largest legal values and values past them in each field.
    task automatic test_overflow();
        send_text("bytes 99999999999999999999-1/2", 1, 1);
        send_text("bytes 0-18446744073709551614/18446744073709551615", 1, 1);
        send_text("bytes 0-18446744073709551616/18446744073709551617", 1, 1);
        send_text("bytes 0-5/18446744073709551616", 1, 1);
    endtask

    // ------------------------------------------------------------------
    // Random headers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 20));
            1: return 64'($urandom_range(0, 100000));
            2: return {$urandom, $urandom};
            default: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
        endcase
    endfunction

    // Decimal text of a value, now and then pushed past 64 bits by an extra digit.
    function automatic void append_number(logic [63:0] v);
        append($sformatf("%0d", v));
        if ($urandom_range(0, 19) == 0) append("9");
    endfunction

    function automatic void build_random_header();
        string       charset;
        logic [63:0] start_v, end_v, size_v;
        int          r;
        charset = "bytes0123456789-/* ";
        msg_bytes.delete();
        // Plain noise, biased toward the characters the parser cares about.
        if ($urandom_range(0, 99) < 10) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 1)) msg_bytes.push_back(charset[$urandom_range(0, 18)]);
                else msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
            return;
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) append(" ");
        append("bytes");
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : 1) append(" ");

        r = $urandom_range(0, 99);
        if (r < 65) append("0");
        else if (r < 75) append("00");
        else begin
            start_v = rand_value();
            append_number(start_v);
        end
        append("-");

        size_v = rand_value();
        r = $urandom_range(0, 99);
        if (r < 50) end_v = size_v - 64'd1;
        else if (r < 75) end_v = size_v == 0 ? 64'd0 : {$urandom, $urandom} % size_v;
        else end_v = rand_value();
        append_number(end_v);
        append("/");

        r = $urandom_range(0, 99);
        if (r < 15) append("*");
        else if (r < 20) begin
            if ($urandom_range(0, 1)) append("x");
        end else append_number(size_v);

        if ($urandom_range(0, 6) == 0) begin
            append(" ");
            repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end

        // Break a few well-formed headers: one byte overwritten or the tail cut.
        r = $urandom_range(0, 99);
        if (r < 10) msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        else if (r < 16) begin
            r = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > r) msg_bytes.delete(msg_bytes.size() - 1);
        end
    endfunction

    task automatic test_random_headers();
        while (bytes_sent < 1000 || msgs_sent < 60) begin
            // Redraw the idle pattern now and then, so some stretches run back to back.
            if (msgs_sent % 8 == 0) begin
                src_gaps_on    = $urandom_range(0, 3) != 0;
                sink_stalls_on = $urandom_range(0, 3) != 0;
            end
            build_random_header();
            send_message(1'($urandom), 1'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        in_bus.valid          = 1'b0;
        in_bus.header_byte    = '0;
        in_bus.final_byte     = 1'b0;
        in_bus.piece_is_front = 1'b0;
        in_bus.piece_is_back  = 1'b0;
        out_bus.ready         = 1'b0;
        clear_parser();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_position_choice();
        test_malformed_text();
        test_range_fields();
        test_size_field();
        test_overflow();
        test_random_headers();

        in_bus.valid <= 1'b0;
        // Drain every outstanding position, then allow for the pipeline.
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
